// ===== rtl/core/awca_pkg.sv =====
// Shared types and constants for the alpha-weighted cell accumulator.
`default_nettype none

package awca_pkg;

  // Request codes
  localparam logic [1:0] REQ_ADD_CELL = 2'd0;
  localparam logic [1:0] REQ_ADD_RUN  = 2'd1;
  localparam logic [1:0] REQ_READ     = 2'd2;
  localparam logic [1:0] REQ_CLEAR    = 2'd3;

  // Cursor width: covers pos + run_length and a store of up to 65536 cells
  localparam int CUR_W = 17;

  // Per-cell sum widths
  localparam int SUM_W   = 32;
  localparam int ALPHA_W = 24;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [11:0] cell_pos;
    logic [12:0] run_length;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [7:0]  alpha_in;
  } in_item_t;

  typedef struct packed {
    logic       cell_valid;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
  } out_item_t;

  // Classified request passed from front to back
  typedef struct packed {
    logic [1:0]       req;
    logic [CUR_W-1:0] first;
    logic [CUR_W-1:0] stop;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
  } cmd_t;

  // Handshake between the front queue and the back engine
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_q_t;

endpackage

`default_nettype wire

// ===== rtl/core/awca_front.sv =====
// Front end: accepts requests, classifies them and queues them for the back end.
`default_nettype none

module awca_front import awca_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_push,
  output logic          in_full,
  input  wire in_item_t in_data,
  input  wire logic     init_busy,
  output cmd_q_t        q_head,
  input  wire logic     q_pop
);

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push_ok;
  logic       pop_ok;
  cmd_t       cls;

  // Classify: a single add is a run of one cell
  always_comb begin
    cls.req   = in_data.req_type;
    cls.first = CUR_W'(in_data.cell_pos);
    cls.red   = in_data.red_in;
    cls.green = in_data.green_in;
    cls.blue  = in_data.blue_in;
    cls.alpha = in_data.alpha_in;
    if (in_data.req_type == REQ_ADD_RUN) begin
      cls.stop = CUR_W'(in_data.cell_pos) + CUR_W'(in_data.run_length);
    end else begin
      cls.stop = CUR_W'(in_data.cell_pos) + CUR_W'(1);
    end
  end

  assign in_full = (cnt_r == 2'd2) || init_busy;
  assign push_ok = in_push && !in_full;
  assign pop_ok  = q_pop && (cnt_r != 2'd0);

  assign q_head.valid = (cnt_r != 2'd0);
  assign q_head.cmd   = slot_r[rd_ptr_r];

  // Queue pointers
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push_ok;
    rd_ptr_nxt = rd_ptr_r ^ pop_ok;
    cnt_nxt    = cnt_r + {1'b0, push_ok} - {1'b0, pop_ok};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push_ok) begin
      slot_r[wr_ptr_r] <= cls;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/awca_div.sv =====
// Restoring divider, one quotient bit per cycle, quotient clamped to 255.
`default_nettype none

module awca_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 24
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  busy,
  output logic [7:0]            quo
);

  localparam int DS_W = DEN_W + 8;
  localparam int W    = ((NUM_W > DS_W) ? NUM_W : DS_W) + 1;

  logic             busy_r;
  logic [3:0]       cnt_r;
  logic [NUM_W-1:0] rem_r;
  logic [DS_W-1:0]  dsh_r;
  logic [7:0]       q_r;
  logic             sat_r;
  logic             fits;

  assign fits = W'(rem_r) >= W'(dsh_r);
  assign busy = busy_r;
  assign quo  = sat_r ? 8'hFF : q_r;

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 4'd8;
    end else if (busy_r) begin
      busy_r <= (cnt_r != 4'd1);
      cnt_r  <= cnt_r - 4'd1;
    end
  end

  // Datapath: quotient above 255 detected up front
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsh_r <= DS_W'(den) << 7;
      q_r   <= 8'd0;
      sat_r <= W'(num) >= (W'(den) << 8);
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= NUM_W'(W'(rem_r) - W'(dsh_r));
      end
      q_r   <= {q_r[6:0], fits};
      dsh_r <= dsh_r >> 1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/awca_back.sv =====
// Back end: cell store, read-modify-write, clear sweep, resolve and result register.
`default_nettype none

module awca_back import awca_pkg::*; #(
  parameter int CELL_COUNT = 4096,
  parameter int COUNT_BITS = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   use_alpha,
  input  wire cmd_q_t q_head,
  output logic        q_pop,
  output logic        init_busy,
  output logic        out_empty,
  input  wire logic   out_pop,
  output out_item_t   out_data
);

  localparam int ADDR_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int ENT_W  = COUNT_BITS + 3 * SUM_W + ALPHA_W;
  localparam int A_LO   = 0;
  localparam int B_LO   = ALPHA_W;
  localparam int G_LO   = ALPHA_W + SUM_W;
  localparam int R_LO   = ALPHA_W + 2 * SUM_W;
  localparam int C_LO   = ALPHA_W + 3 * SUM_W;
  localparam logic [CUR_W-1:0] CELL_END  = CUR_W'(CELL_COUNT);
  localparam logic [CUR_W-1:0] CELL_LAST = CUR_W'(CELL_COUNT - 1);

  localparam logic [2:0] ST_CLR    = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_RUN    = 3'd2;
  localparam logic [2:0] ST_RUN_WR = 3'd3;
  localparam logic [2:0] ST_RCHK   = 3'd4;
  localparam logic [2:0] ST_DIV    = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  logic [ENT_W-1:0] mem [CELL_COUNT];
  logic [ENT_W-1:0] rd_data_r;

  logic [2:0]       state_r, state_nxt;
  logic [CUR_W-1:0] cur_r, cur_nxt;
  logic             init_r, init_nxt;
  cmd_t             cmd_r, cmd_nxt;
  out_item_t        res_r, res_nxt;
  logic             ov_r, ov_nxt;
  out_item_t        od_r, od_nxt;

  logic             rd_en;
  logic             wr_en;
  logic [ENT_W-1:0] wr_data;
  logic             div_start;
  logic             out_free;

  logic [COUNT_BITS-1:0] cnt_old;
  logic [SUM_W-1:0]      r_old, g_old, b_old;
  logic [ALPHA_W-1:0]    a_old;
  logic [COUNT_BITS-1:0] cnt_new;
  logic [SUM_W-1:0]      r_new, g_new, b_new;
  logic [ALPHA_W-1:0]    a_new;
  logic [15:0]           r_prod, g_prod, b_prod;
  logic [SUM_W:0]        r_add, g_add, b_add;
  logic [ALPHA_W:0]      a_add;
  logic                  hit_ok;

  logic       r_busy, g_busy, b_busy, a_busy;
  logic [7:0] r_q, g_q, b_q, a_q;

  // Field split of the stored cell
  always_comb begin
    cnt_old = rd_data_r[C_LO +: COUNT_BITS];
    r_old   = rd_data_r[R_LO +: SUM_W];
    g_old   = rd_data_r[G_LO +: SUM_W];
    b_old   = rd_data_r[B_LO +: SUM_W];
    a_old   = rd_data_r[A_LO +: ALPHA_W];
  end

  // Saturating update for an add
  always_comb begin
    r_prod  = cmd_r.red * cmd_r.alpha;
    g_prod  = cmd_r.green * cmd_r.alpha;
    b_prod  = cmd_r.blue * cmd_r.alpha;
    r_add   = {1'b0, r_old} + (SUM_W + 1)'(r_prod);
    g_add   = {1'b0, g_old} + (SUM_W + 1)'(g_prod);
    b_add   = {1'b0, b_old} + (SUM_W + 1)'(b_prod);
    a_add   = {1'b0, a_old} + (ALPHA_W + 1)'(cmd_r.alpha);
    cnt_new = (&cnt_old) ? cnt_old : cnt_old + COUNT_BITS'(1);
    r_new   = r_add[SUM_W] ? '1 : r_add[SUM_W-1:0];
    g_new   = g_add[SUM_W] ? '1 : g_add[SUM_W-1:0];
    b_new   = b_add[SUM_W] ? '1 : b_add[SUM_W-1:0];
    a_new   = a_add[ALPHA_W] ? '1 : a_add[ALPHA_W-1:0];
    hit_ok  = (cnt_old != '0) && (a_old != '0);
  end

  // Resolve dividers, all four run in lockstep
  awca_div #(.NUM_W(SUM_W), .DEN_W(ALPHA_W)) u_div_r (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(r_old), .den(a_old),
    .busy(r_busy), .quo(r_q)
  );
  awca_div #(.NUM_W(SUM_W), .DEN_W(ALPHA_W)) u_div_g (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(g_old), .den(a_old),
    .busy(g_busy), .quo(g_q)
  );
  awca_div #(.NUM_W(SUM_W), .DEN_W(ALPHA_W)) u_div_b (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(b_old), .den(a_old),
    .busy(b_busy), .quo(b_q)
  );
  awca_div #(.NUM_W(ALPHA_W), .DEN_W(COUNT_BITS)) u_div_a (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(a_old), .den(cnt_old),
    .busy(a_busy), .quo(a_q)
  );

  assign out_free = !ov_r || out_pop;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    init_nxt  = init_r;
    cmd_nxt   = cmd_r;
    res_nxt   = res_r;
    ov_nxt    = ov_r && !out_pop;
    od_nxt    = od_r;
    q_pop     = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    wr_data   = '0;
    div_start = 1'b0;
    unique case (state_r)
      ST_CLR: begin
        wr_en = 1'b1;
        if (cur_r == CELL_LAST) begin
          init_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          cur_nxt = cur_r + CUR_W'(1);
        end
      end
      ST_IDLE: begin
        if (q_head.valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_head.cmd;
          cur_nxt = q_head.cmd.first;
          res_nxt = '0;
          case (q_head.cmd.req)
            REQ_CLEAR: begin
              cur_nxt   = '0;
              state_nxt = ST_CLR;
            end
            REQ_READ: begin
              if (q_head.cmd.first < CELL_END) begin
                rd_en     = 1'b1;
                state_nxt = ST_RCHK;
              end else begin
                state_nxt = ST_OUT;
              end
            end
            default: begin
              state_nxt = ST_RUN;
            end
          endcase
        end
      end
      ST_RUN: begin
        if ((cur_r < cmd_r.stop) && (cur_r < CELL_END)) begin
          rd_en     = 1'b1;
          state_nxt = ST_RUN_WR;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RUN_WR: begin
        wr_en     = 1'b1;
        wr_data   = {cnt_new, r_new, g_new, b_new, a_new};
        cur_nxt   = cur_r + CUR_W'(1);
        state_nxt = ST_RUN;
      end
      ST_RCHK: begin
        if (hit_ok) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_DIV: begin
        if (!(r_busy || g_busy || b_busy || a_busy)) begin
          res_nxt.cell_valid = 1'b1;
          res_nxt.red_out    = r_q;
          res_nxt.green_out  = g_q;
          res_nxt.blue_out   = b_q;
          res_nxt.alpha_out  = use_alpha ? a_q : 8'hFF;
          state_nxt          = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          od_nxt    = res_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      cur_r   <= '0;
      init_r  <= 1'b1;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      init_r  <= init_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    res_r <= res_nxt;
    od_r  <= od_nxt;
  end

  // Cell store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cur_r[ADDR_W-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[cur_nxt[ADDR_W-1:0]];
    end
  end

  assign init_busy = init_r;
  assign out_empty = !ov_r;
  assign out_data  = od_r;

endmodule

`default_nettype wire

// ===== rtl/core/alpha_weighted_cell_accumulator_top.sv =====
// Top level of the alpha-weighted cell accumulator.
//
//   channel   ports                         moves
//   input     in_push, in_full, in_data     one request per accepted push
//   result    out_empty, out_pop, out_data  one resolved cell per read request
//   config    cfg_we, cfg_wdata             use_alpha bit
//
// Add cell is a run of one cell; add run reads each cell that lies inside the store and
// then writes it back, through the single-port cell memory.
// Read: memory read and check, the 8-step bit-serial dividers (skipped when the cell's
// count or alpha sum is zero), then the load of the result register.
// Clear sweeps the store, one cell written per cycle.
// After reset the same sweep runs, with in_full held high.
// A two-entry queue and the result register let either side stall without blocking.
`default_nettype none

module alpha_weighted_cell_accumulator_top import awca_pkg::*; #(
  parameter int CELL_COUNT = 4096,
  parameter int COUNT_BITS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_push,
  output logic          in_full,
  input  wire in_item_t in_data,
  output logic          out_empty,
  input  wire logic     out_pop,
  output out_item_t     out_data,
  input  wire logic     cfg_we,
  input  wire logic     cfg_wdata
);

  logic   use_alpha_r;
  cmd_q_t q_head;
  logic   q_pop;
  logic   init_busy;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_alpha_r <= 1'b0;
    end else if (cfg_we) begin
      use_alpha_r <= cfg_wdata;
    end
  end

  awca_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .init_busy (init_busy),
    .q_head    (q_head),
    .q_pop     (q_pop)
  );

  awca_back #(
    .CELL_COUNT (CELL_COUNT),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .use_alpha (use_alpha_r),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
